@@ src/lphs_pkg.sv @@
// lphs_pkg: shared types and codes for the linear probing hash set
// used by linear_probe_hash_set; no dependencies

package lphs_pkg;

    localparam int DEPTH_DEF    = 256;
    localparam int KEY_BITS_DEF = 32;

    localparam int HASH_W   = 32;
    localparam int DIV_STEP = 4;
    localparam int DIV_CYC  = HASH_W / DIV_STEP;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;

    localparam logic [1:0] SLOT_EMPTY   = 2'd0;
    localparam logic [1:0] SLOT_FILLED  = 2'd1;
    localparam logic [1:0] SLOT_DELETED = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_ABSENT  = 2'd1;
    localparam logic [1:0] ST_PRESENT = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [8:0] TABLE_SIZE_RST = 9'd256;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_PROBE,
        S_COMMIT
    } lphs_state_t;

endpackage

@@ src/lphs_ram.sv @@
// lphs_ram: generic single write port ram with registered read
// no dependencies

module lphs_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/linear_probe_hash_set.sv @@
// linear_probe_hash_set: open addressing hash set with linear probing
// depends on lphs_pkg and lphs_ram
//
// usage:
//   a request (kind, key, key_hash) is taken at a clock edge with start high
//   and busy low. kind: add, remove, find (kind three acts as find).
//   one result per request appears on found, slot_index, stored_key,
//   element_count and status for exactly one cycle with done high; the
//   receiver must take it then. the user must write table_size through cfg_we / cfg_data
//   only while the block is idle; the block itself does not enforce this.
// timing:
//   the start slot key_hash mod the effective table size comes from a 4 bit
//   per cycle restoring remainder unit. the probe then reads one slot per
//   cycle from the slot ram and checks each slot in the cycle after its
//   read; a commit state then writes the ram when an add or remove
//   succeeds. busy stays high while a request is in progress; busy falls
//   and done rises at the same edge.
// reset:
//   after reset a clearing pass marks every slot empty, one per cycle,
//   with busy high. table_size resets to 256.

module linear_probe_hash_set #(
    parameter int DEPTH    = lphs_pkg::DEPTH_DEF,
    parameter int KEY_BITS = lphs_pkg::KEY_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [31:0] key,
    input  logic [31:0] key_hash,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_data,
    output logic        done,
    output logic        found,
    output logic [7:0]  slot_index,
    output logic [31:0] stored_key,
    output logic [8:0]  element_count,
    output logic [1:0]  status
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CW    = (IDX_W + 1 > 10) ? IDX_W + 1 : 10;
    localparam int KW    = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int RW    = KW + 2;
    localparam int DCW   = $clog2(lphs_pkg::DIV_CYC);

    lphs_pkg::lphs_state_t state_reg, state_next;

    logic [IDX_W-1:0]            clr_addr_reg, clr_addr_next;
    logic [DCW-1:0]              div_cnt_reg, div_cnt_next;
    logic                        chk_vld_reg, chk_vld_next;
    logic [8:0]                  total_reg, total_next;
    logic [8:0]                  table_size_reg, table_size_next;
    logic                        done_reg, done_next;

    logic [CW-1:0]               rem_reg, rem_next;
    logic [lphs_pkg::HASH_W-1:0] hash_reg, hash_next;
    logic [1:0]                  kind_reg, kind_next;
    logic [KW-1:0]               key_reg, key_next;
    logic [CW-1:0]               size_reg, size_next;
    logic [CW-1:0]               addr_reg, addr_next;
    logic [CW-1:0]               chk_pos_reg, chk_pos_next;
    logic [CW-1:0]               n_reg, n_next;
    logic                        seen_del_reg, seen_del_next;
    logic [CW-1:0]               first_del_reg, first_del_next;
    logic                        hit_reg, hit_next;
    logic [CW-1:0]               pos_reg, pos_next;
    logic                        have_reg, have_next;
    logic                        found_reg, found_next;
    logic [7:0]                  slot_reg, slot_next;
    logic [31:0]                 skey_reg, skey_next;
    logic [1:0]                  status_reg, status_next;

    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    logic [RW-1:0]               ram_wdata;
    logic [RW-1:0]               ram_rdata;

    logic [CW-1:0]               act_size;
    logic [CW-1:0]               tsz_ext;
    logic [CW-1:0]               div_r;
    logic [lphs_pkg::HASH_W-1:0] div_h;
    logic [1:0]                  rd_st;
    logic [KW-1:0]               rd_key;
    logic                        rd_hit;
    logic                        rd_del;
    logic                        last_probe;
    logic [CW-1:0]               addr_inc;

    lphs_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // zero acts as one, sizes past the memory act as the memory depth
    always_comb
    begin
        tsz_ext = CW'(table_size_reg);
        if (table_size_reg == 9'd0)
        begin
            act_size = CW'(1);
        end
        else if (tsz_ext > CW'(DEPTH))
        begin
            act_size = CW'(DEPTH);
        end
        else
        begin
            act_size = tsz_ext;
        end
    end

    // remainder unit: DIV_STEP restoring steps per cycle
    always_comb
    begin
        div_r = rem_reg;
        div_h = hash_reg;
        for (int j = 0; j < lphs_pkg::DIV_STEP; j++)
        begin
            div_r = {div_r[CW-2:0], div_h[lphs_pkg::HASH_W-1]};
            div_h = {div_h[lphs_pkg::HASH_W-2:0], 1'b0};
            if (div_r >= size_reg)
            begin
                div_r = div_r - size_reg;
            end
        end
    end

    assign rd_st      = ram_rdata[RW-1:KW];
    assign rd_key     = ram_rdata[KW-1:0];
    assign rd_hit     = (rd_st == lphs_pkg::SLOT_FILLED) && (rd_key == key_reg);
    assign rd_del     = (rd_st == lphs_pkg::SLOT_DELETED);
    assign last_probe = ((n_reg + CW'(1)) == size_reg);
    assign addr_inc   = ((addr_reg + CW'(1)) == size_reg) ? '0 : addr_reg + CW'(1);

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        div_cnt_next    = div_cnt_reg;
        chk_vld_next    = 1'b0;
        total_next      = total_reg;
        table_size_next = table_size_reg;
        done_next       = 1'b0;
        rem_next        = rem_reg;
        hash_next       = hash_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        chk_pos_next    = chk_pos_reg;
        n_next          = n_reg;
        seen_del_next   = seen_del_reg;
        first_del_next  = first_del_reg;
        hit_next        = hit_reg;
        pos_next        = pos_reg;
        have_next       = have_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        skey_next       = skey_reg;
        status_next     = status_reg;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg[IDX_W-1:0];
        ram_wdata       = {lphs_pkg::SLOT_FILLED, key_reg};

        if (cfg_we)
        begin
            table_size_next = cfg_data;
        end

        unique case (state_reg)
            lphs_pkg::S_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = {lphs_pkg::SLOT_EMPTY, {KW{1'b0}}};
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == IDX_W'(DEPTH - 1))
                begin
                    state_next = lphs_pkg::S_IDLE;
                end
            end

            lphs_pkg::S_IDLE:
            begin
                if (start)
                begin
                    kind_next     = kind;
                    key_next      = key[KW-1:0];
                    hash_next     = key_hash;
                    size_next     = act_size;
                    rem_next      = '0;
                    div_cnt_next  = '0;
                    state_next    = lphs_pkg::S_DIV;
                end
            end

            lphs_pkg::S_DIV:
            begin
                rem_next     = div_r;
                hash_next    = div_h;
                div_cnt_next = div_cnt_reg + DCW'(1);
                if (div_cnt_reg == DCW'(lphs_pkg::DIV_CYC - 1))
                begin
                    addr_next     = div_r;
                    n_next        = '0;
                    seen_del_next = 1'b0;
                    first_del_next = '0;
                    state_next    = lphs_pkg::S_PROBE;
                end
            end

            lphs_pkg::S_PROBE:
            begin
                // read issued every cycle, checked in the cycle after
                addr_next    = addr_inc;
                chk_pos_next = addr_reg;
                chk_vld_next = 1'b1;
                if (chk_vld_reg)
                begin
                    n_next = n_reg + CW'(1);
                    if (rd_st == lphs_pkg::SLOT_EMPTY)
                    begin
                        hit_next   = 1'b0;
                        pos_next   = seen_del_reg ? first_del_reg : chk_pos_reg;
                        have_next  = 1'b1;
                        state_next = lphs_pkg::S_COMMIT;
                    end
                    else if (rd_hit)
                    begin
                        hit_next   = 1'b1;
                        pos_next   = chk_pos_reg;
                        have_next  = 1'b1;
                        state_next = lphs_pkg::S_COMMIT;
                    end
                    else
                    begin
                        if (rd_del && !seen_del_reg)
                        begin
                            seen_del_next  = 1'b1;
                            first_del_next = chk_pos_reg;
                        end
                        if (last_probe)
                        begin
                            hit_next   = 1'b0;
                            pos_next   = (rd_del && !seen_del_reg) ? chk_pos_reg
                                                                   : first_del_reg;
                            have_next  = seen_del_reg || rd_del;
                            state_next = lphs_pkg::S_COMMIT;
                        end
                    end
                end
            end

            lphs_pkg::S_COMMIT:
            begin
                found_next = hit_reg;
                slot_next  = 8'd0;
                skey_next  = 32'd0;
                done_next  = 1'b1;
                state_next = lphs_pkg::S_IDLE;
                case (kind_reg)
                    lphs_pkg::KIND_ADD:
                    begin
                        if (hit_reg)
                        begin
                            slot_next   = pos_reg[7:0];
                            status_next = lphs_pkg::ST_PRESENT;
                        end
                        else if ((CW'(total_reg) >= size_reg) || !have_reg)
                        begin
                            status_next = lphs_pkg::ST_FULL;
                        end
                        else
                        begin
                            ram_we      = 1'b1;
                            ram_wdata   = {lphs_pkg::SLOT_FILLED, key_reg};
                            total_next  = total_reg + 9'd1;
                            slot_next   = pos_reg[7:0];
                            status_next = lphs_pkg::ST_DONE;
                        end
                    end

                    lphs_pkg::KIND_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            ram_we      = 1'b1;
                            ram_wdata   = {lphs_pkg::SLOT_DELETED, key_reg};
                            if (total_reg != 9'd0)
                            begin
                                total_next = total_reg - 9'd1;
                            end
                            slot_next   = pos_reg[7:0];
                            status_next = lphs_pkg::ST_DONE;
                        end
                        else
                        begin
                            status_next = lphs_pkg::ST_ABSENT;
                        end
                    end

                    default:
                    begin
                        // find; a hit means the stored key equals the request key
                        if (hit_reg)
                        begin
                            slot_next   = pos_reg[7:0];
                            skey_next   = 32'(key_reg);
                            status_next = lphs_pkg::ST_DONE;
                        end
                        else
                        begin
                            status_next = lphs_pkg::ST_ABSENT;
                        end
                    end
                endcase
            end

            default:
            begin
                state_next = lphs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lphs_pkg::S_CLEAR;
            clr_addr_reg   <= '0;
            div_cnt_reg    <= '0;
            chk_vld_reg    <= 1'b0;
            total_reg      <= 9'd0;
            table_size_reg <= lphs_pkg::TABLE_SIZE_RST;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            div_cnt_reg    <= div_cnt_next;
            chk_vld_reg    <= chk_vld_next;
            total_reg      <= total_next;
            table_size_reg <= table_size_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        hash_reg      <= hash_next;
        kind_reg      <= kind_next;
        key_reg       <= key_next;
        size_reg      <= size_next;
        addr_reg      <= addr_next;
        chk_pos_reg   <= chk_pos_next;
        n_reg         <= n_next;
        seen_del_reg  <= seen_del_next;
        first_del_reg <= first_del_next;
        hit_reg       <= hit_next;
        pos_reg       <= pos_next;
        have_reg      <= have_next;
        found_reg     <= found_next;
        slot_reg      <= slot_next;
        skey_reg      <= skey_next;
        status_reg    <= status_next;
    end

    assign busy          = (state_reg != lphs_pkg::S_IDLE);
    assign done          = done_reg;
    assign found         = found_reg;
    assign slot_index    = slot_reg;
    assign stored_key    = skey_reg;
    assign element_count = total_reg;
    assign status        = status_reg;

    a_done_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == lphs_pkg::S_COMMIT))
        else $error("result strobe without a commit cycle");

    a_total_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != lphs_pkg::S_COMMIT) |=> $stable(total_reg))
        else $error("element count changed outside commit");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == lphs_pkg::ST_FULL)) |-> (!found_reg && (slot_reg == 8'd0)))
        else $error("table full result with a slot or hit");

    a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && found_reg) |->
            ((status_reg == lphs_pkg::ST_DONE) || (status_reg == lphs_pkg::ST_PRESENT)))
        else $error("hit reported with a miss status");

endmodule

@@ tb/sv/linear_probe_hash_set_checker.sv @@
// linear_probe_hash_set_checker: keeps its own copy of the hash set, predicts the
// reply to every accepted request and compares each strobed reply with the oldest one
// depends on lphs_pkg

module linear_probe_hash_set_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  kind,
    input  logic [31:0] key,
    input  logic [31:0] key_hash,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_data,
    input  logic        done,
    input  logic        found,
    input  logic [7:0]  slot_index,
    input  logic [31:0] stored_key,
    input  logic [8:0]  element_count,
    input  logic [1:0]  status,
    output int unsigned outstanding,
    output int unsigned fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        found;
        logic [7:0]  slot;
        logic [31:0] skey;
        logic [8:0]  count;
        logic [1:0]  status;
    } set_reply_t;

    logic [1:0]  slot_state [256];
    logic [31:0] slot_key   [256];
    logic [8:0]  filled_total;
    logic [8:0]  size_reg;
    set_reply_t  awaited_replies [$];

    // walks the table like the block does and applies the request to the copy
    function automatic set_reply_t apply_set_request(input logic [1:0] op,
                                                     input logic [31:0] k,
                                                     input logic [31:0] h);
        int unsigned span;
        int unsigned idx;
        int unsigned target;
        int unsigned first_del;
        int unsigned n;
        bit          seen_del;
        bit          hit;
        bit          have_slot;
        bit          stop;
        set_reply_t  r;

        span = (size_reg == 9'd0) ? 1 : ((size_reg > 9'd256) ? 256 : size_reg);
        idx = h % span;
        target = 0;
        first_del = 0;
        seen_del = 1'b0;
        hit = 1'b0;
        have_slot = 1'b0;
        stop = 1'b0;
        for (n = 0; n < span && !stop; n++)
        begin
            if (slot_state[idx] == lphs_pkg::SLOT_EMPTY)
            begin
                stop = 1'b1;
                have_slot = 1'b1;
                target = seen_del ? first_del : idx;
            end
            else if (slot_state[idx] == lphs_pkg::SLOT_FILLED && slot_key[idx] == k)
            begin
                stop = 1'b1;
                hit = 1'b1;
                target = idx;
            end
            else if (slot_state[idx] == lphs_pkg::SLOT_DELETED && !seen_del)
            begin
                seen_del = 1'b1;
                first_del = idx;
            end
            idx = (idx + 1 == span) ? 0 : idx + 1;
        end
        // probe ran out of slots without an empty one or a hit
        if (!stop)
        begin
            target = first_del;
            have_slot = seen_del;
        end

        r = '0;
        r.found = hit;
        if (op == lphs_pkg::KIND_ADD)
        begin
            if (hit)
            begin
                r.slot = target[7:0];
                r.status = lphs_pkg::ST_PRESENT;
            end
            else if (filled_total >= span || !have_slot)
            begin
                r.status = lphs_pkg::ST_FULL;
            end
            else
            begin
                slot_state[target] = lphs_pkg::SLOT_FILLED;
                slot_key[target] = k;
                filled_total = filled_total + 9'd1;
                r.slot = target[7:0];
                r.status = lphs_pkg::ST_DONE;
            end
        end
        else if (op == lphs_pkg::KIND_REMOVE)
        begin
            if (hit)
            begin
                slot_state[target] = lphs_pkg::SLOT_DELETED;
                if (filled_total != 9'd0)
                    filled_total = filled_total - 9'd1;
                r.slot = target[7:0];
                r.status = lphs_pkg::ST_DONE;
            end
            else
            begin
                r.status = lphs_pkg::ST_ABSENT;
            end
        end
        else
        begin
            // find, kind three included
            if (hit)
            begin
                r.slot = target[7:0];
                r.skey = slot_key[target];
                r.status = lphs_pkg::ST_DONE;
            end
            else
            begin
                r.status = lphs_pkg::ST_ABSENT;
            end
        end
        r.count = filled_total;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        set_reply_t got;
        set_reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 256; i++)
            begin
                slot_state[i] = lphs_pkg::SLOT_EMPTY;
                slot_key[i] = '0;
            end
            filled_total = '0;
            size_reg = lphs_pkg::TABLE_SIZE_RST;
            awaited_replies.delete();
            fail_count = 0;
        end
        else
        begin
            // a reply and the next request can meet at one edge: retire first
            if (done)
            begin
                got = {found, slot_index, stored_key, element_count, status};
                if (awaited_replies.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: reply with no request waiting: found=%0d slot=%0d",
                                 $realtime, got.found, got.slot);
                    fail_count++;
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("%0t: reply mismatch: expected found=%0d slot=%0d key=%h count=%0d status=%0d",
                                     $realtime, want.found, want.slot, want.skey,
                                     want.count, want.status);
                            $display("%0t: reply mismatch: got found=%0d slot=%0d key=%h count=%0d status=%0d",
                                     $realtime, got.found, got.slot, got.skey,
                                     got.count, got.status);
                        end
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
                size_reg = cfg_data;
            if (start && !busy)
                awaited_replies.push_back(apply_set_request(kind, key, key_hash));
        end
        outstanding = awaited_replies.size();
    end

endmodule

@@ tb/sv/linear_probe_hash_set_tb.sv @@
// linear_probe_hash_set_tb: drives requests and table size writes into the hash set
// and gives the verdict; depends on lphs_pkg, linear_probe_hash_set and
// linear_probe_hash_set_checker

module linear_probe_hash_set_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_FIND     = 2'd2;
    localparam logic [1:0] KIND_FIND_ALT = 2'd3;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int NPHASE = 11;

    int unsigned phase_size  [NPHASE] = '{1, 0, 2, 256, 7, 300, 3, 16, 64, 511, 5};
    int unsigned phase_items [NPHASE] = '{40, 30, 50, 250, 80, 60, 50, 80, 100, 100, 60};
    int unsigned phase_adds  [NPHASE] = '{50, 50, 50, 75, 50, 55, 45, 55, 60, 50, 50};

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  kind;
    logic [31:0] key;
    logic [31:0] key_hash;
    logic        cfg_we;
    logic [8:0]  cfg_data;
    logic        done;
    logic        found;
    logic [7:0]  slot_index;
    logic [31:0] stored_key;
    logic [8:0]  element_count;
    logic [1:0]  status;

    int unsigned outstanding;
    int unsigned fail_count;
    int unsigned cycle_count = 0;

    logic [31:0] pool_key  [400];
    logic [31:0] pool_hash [400];

    linear_probe_hash_set dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .key           (key),
        .key_hash      (key_hash),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .done          (done),
        .found         (found),
        .slot_index    (slot_index),
        .stored_key    (stored_key),
        .element_count (element_count),
        .status        (status)
    );

    linear_probe_hash_set_checker set_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .key           (key),
        .key_hash      (key_hash),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .done          (done),
        .found         (found),
        .slot_index    (slot_index),
        .stored_key    (stored_key),
        .element_count (element_count),
        .status        (status),
        .outstanding   (outstanding),
        .fail_count    (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input logic [1:0] op, input logic [31:0] k,
                                input logic [31:0] h);
        start <= 1'b1;
        kind <= op;
        key <= k;
        key_hash <= h;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic wait_replies_in();
        do @(negedge clk); while (outstanding != 0 || busy);
    endtask

    task automatic write_table_size(input logic [8:0] value);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int unsigned eff;
        int unsigned pool_len;
        int unsigned r;
        int unsigned pick;
        logic [1:0]  op;
        logic [31:0] k;
        logic [31:0] h;
        bit          idle_on;

        rst_n = 1'b0;
        start = 1'b0;
        kind = lphs_pkg::KIND_ADD;
        key = '0;
        key_hash = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table, extremes, collisions with wrap, deleted slot reuse
        send_request(KIND_FIND, 32'h0, 32'h0);
        send_request(lphs_pkg::KIND_REMOVE, 32'h0, 32'h0);
        send_request(lphs_pkg::KIND_ADD, 32'h0, 32'h0);
        send_request(lphs_pkg::KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(lphs_pkg::KIND_ADD, 32'h0, 32'h0);
        send_request(lphs_pkg::KIND_ADD, 32'h1, 32'd255);
        send_request(KIND_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(KIND_FIND_ALT, 32'h1, 32'd255);
        send_request(lphs_pkg::KIND_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(KIND_FIND, 32'h1, 32'd255);
        send_request(lphs_pkg::KIND_ADD, 32'h2, 32'd511);
        send_request(KIND_FIND, 32'h3, 32'd511);
        send_request(lphs_pkg::KIND_REMOVE, 32'h1, 32'd255);
        send_request(lphs_pkg::KIND_ADD, 32'h1, 32'd255);
        send_request(lphs_pkg::KIND_ADD, 32'hAAAA_AAAA, 32'h5555_5555);
        send_request(KIND_FIND, 32'h5555_5555, 32'hAAAA_AAAA);
        send_request(KIND_FIND_ALT, 32'hAAAA_AAAA, 32'h5555_5555);
        send_request(lphs_pkg::KIND_REMOVE, 32'h0, 32'h0);
        start <= 1'b0;
        wait_replies_in();

        for (int p = 0; p < NPHASE; p++)
        begin
            write_table_size(phase_size[p][8:0]);
            eff = (phase_size[p] == 0) ? 1 : ((phase_size[p] > 256) ? 256 : phase_size[p]);
            pool_len = eff * 3 / 2 + 2;
            for (int i = 0; i < pool_len; i++)
            begin
                pool_key[i] = $urandom;
                pool_hash[i] = $urandom;
            end
            idle_on = (p != NPHASE - 1) && (p % 3 != 2);
            for (int i = 0; i < phase_items[p]; i++)
            begin
                if (idle_on && $urandom_range(0, 3) == 0)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 10)) @(negedge clk);
                end
                else if ((p != NPHASE - 1) && $urandom_range(0, 39) == 0)
                begin
                    start <= 1'b0;
                    wait_replies_in();
                end
                r = $urandom_range(0, 99);
                if (r < phase_adds[p])
                    op = lphs_pkg::KIND_ADD;
                else if (r < phase_adds[p] + 20)
                    op = lphs_pkg::KIND_REMOVE;
                else
                    op = ($urandom_range(0, 3) == 0) ? KIND_FIND_ALT : KIND_FIND;
                pick = $urandom_range(0, pool_len - 1);
                k = pool_key[pick];
                h = pool_hash[pick];
                r = $urandom_range(0, 99);
                // mostly consistent key/hash pairs, some noise and mismatched hashes
                if (r < 12)
                begin
                    k = $urandom;
                    h = $urandom;
                end
                else if (r < 17)
                begin
                    h = $urandom;
                end
                send_request(op, k, h);
            end
            start <= 1'b0;
            wait_replies_in();
        end

        repeat (300) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
src/lphs_pkg.sv
src/lphs_ram.sv
src/linear_probe_hash_set.sv
tb/sv/linear_probe_hash_set_checker.sv
tb/sv/linear_probe_hash_set_tb.sv
